// ----- hw/rtl/vlmf_pkg.sv -----
`timescale 1ns / 1ps

package vlmf_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DEF_BUF_BYTES = 16384;
    localparam int DEF_SLOTS     = 256;
    localparam int DEF_MAX_MSG   = 64;

    // Fixed field widths.
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
        logic [LEN_W-1:0]  out_length;
        logic [STAT_W-1:0] status;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;  // clear one descriptor slot
        logic push;      // store one pushed byte
        logic req;       // latch a pop or peek and read the head descriptor
        logic resolve;   // act on the head descriptor
        logic issue;     // read one message byte from the ring
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;    // the clearing sweep is on its last slot
        logic q_room;      // an immediate result can be queued this cycle
        logic rd_room;     // a byte read issued now has a place to land
        logic stream;      // the head message is to be streamed out
        logic last_issue;  // the next byte read is the message's last
    } t_sts;

endpackage

// ----- hw/rtl/variable_length_message_fifo.sv -----
`timescale 1ns / 1ps
// Byte pushes are accepted back to back, one item per cycle, while the controller is idle.
// A pop or peek first registers the head descriptor, then acts on it once the result queue
// has room; a single result (peek, empty, drop) is queued by that step, while a streamed pop
// then issues byte reads, each registered before being queued, one per cycle while the queue
// has room. The next item is taken in the cycle after the last byte read is issued.
// After reset the descriptor ring is cleared one slot per cycle, input stalled.
module variable_length_message_fifo #(
    parameter int BUF_BYTES = vlmf_pkg::DEF_BUF_BYTES,
    parameter int SLOTS     = vlmf_pkg::DEF_SLOTS,
    parameter int MAX_MSG   = vlmf_pkg::DEF_MAX_MSG
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [vlmf_pkg::KIND_W-1:0] i_kind,
    input  logic [vlmf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_byte_last,
    input  logic [vlmf_pkg::LEN_W-1:0]  i_msg_length,
    input  logic [vlmf_pkg::LEN_W-1:0]  i_read_limit,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [vlmf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last,
    output logic [vlmf_pkg::LEN_W-1:0]  o_out_length,
    output logic [vlmf_pkg::STAT_W-1:0] o_status
);

    // The controller only sequences; every pointer, memory and result lives in
    // the datapath. They talk through one command struct and one status struct.
    vlmf_pkg::t_cmd cmd;
    vlmf_pkg::t_sts sts;
    vlmf_pkg::t_res res;

    // The controller owns the request stall: requests are taken only while it is
    // idle, which also keeps the clearing sweep free of pushes.
    vlmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath ends in a two-entry result queue, so byte reads keep flowing
    // while a finished result waits for the consumer, and a stalled result holds.
    vlmf_dp #(
        .BUF_BYTES (BUF_BYTES),
        .SLOTS     (SLOTS),
        .MAX_MSG   (MAX_MSG)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_byte_last  (i_byte_last),
        .i_msg_length (i_msg_length),
        .i_read_limit (i_read_limit),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_item       (res)
    );

    // Unpack the queued result onto the output ports.
    assign o_out_byte   = res.out_byte;
    assign o_out_last   = res.out_last;
    assign o_out_length = res.out_length;
    assign o_status     = res.status;

endmodule

// ----- hw/rtl/vlmf_outq.sv -----
`timescale 1ns / 1ps

// Two-entry result queue that parts the datapath from the output handshake.
module vlmf_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_enq,
    input  vlmf_pkg::t_res i_item,
    input  logic           i_stall,
    output logic           o_valid,
    output vlmf_pkg::t_res o_item,
    output logic [1:0]     o_count,
    output logic           o_deq
);

    vlmf_pkg::t_res r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_deq   = o_valid && !i_stall;
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_enq) begin
                r_wp <= ~r_wp;
            end
            if (o_deq) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_enq, o_deq})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- hw/rtl/vlmf_dp.sv -----
`timescale 1ns / 1ps

// Datapath: byte ring, descriptor ring, pointers, fill level and result queue.
module vlmf_dp #(
    parameter int BUF_BYTES = vlmf_pkg::DEF_BUF_BYTES,
    parameter int SLOTS     = vlmf_pkg::DEF_SLOTS,
    parameter int MAX_MSG   = vlmf_pkg::DEF_MAX_MSG
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vlmf_pkg::t_cmd                i_cmd,
    output vlmf_pkg::t_sts                o_sts,
    input  logic [vlmf_pkg::KIND_W-1:0]   i_kind,
    input  logic [vlmf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_byte_last,
    input  logic [vlmf_pkg::LEN_W-1:0]    i_msg_length,
    input  logic [vlmf_pkg::LEN_W-1:0]    i_read_limit,
    input  logic                          i_stall,
    output logic                          o_valid,
    output vlmf_pkg::t_res                o_item
);

    localparam int PTR_W  = $clog2(BUF_BYTES);
    localparam int FILL_W = $clog2(BUF_BYTES + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = vlmf_pkg::LEN_W;

    typedef struct packed {
        logic             valid;
        logic [PTR_W-1:0] start;
        logic [LEN_W-1:0] len;
    } t_desc;

    // Memories.
    logic [vlmf_pkg::BYTE_W-1:0] r_byte_mem [BUF_BYTES];
    t_desc                       r_desc_mem [SLOTS];

    // Write side.
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_msg_start;
    logic              r_in_msg;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_slot_wr;
    logic [SLOT_W-1:0] r_slot_rd;
    logic [SLOT_W-1:0] r_clr_idx;

    // Latched request.
    logic [vlmf_pkg::KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]            r_limit;
    logic                        r_empty;
    t_desc                       r_desc_rd;

    // Streaming.
    logic [PTR_W-1:0]            r_pos;
    logic [LEN_W-1:0]            r_cnt;
    logic [LEN_W-1:0]            r_len;
    logic                        r_rd_pend;
    logic                        r_rd_last;
    logic [vlmf_pkg::BYTE_W-1:0] r_rd_data;

    logic [LEN_W-1:0]  len_sat;
    logic [PTR_W-1:0]  start_now;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [SLOT_W-1:0] slot_wr_inc;
    logic [SLOT_W-1:0] slot_rd_inc;
    logic [PTR_W-1:0]  pos_inc;
    logic [SUM_W-1:0]  fill_sum;
    logic [FILL_W-1:0] fill_base;
    logic              head_none;
    logic              is_pop;
    logic              too_long;
    logic              desc_we;
    logic [SLOT_W-1:0] desc_wa;
    t_desc             desc_wd;
    logic              enq;
    vlmf_pkg::t_res    enq_item;
    logic [1:0]        q_count;
    logic              q_deq;
    logic [2:0]        q_after;

    assign len_sat     = (i_msg_length > LEN_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : i_msg_length;
    assign start_now   = r_in_msg ? r_msg_start : r_wr_ptr;
    assign wr_ptr_inc  = (r_wr_ptr == PTR_W'(BUF_BYTES - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign pos_inc     = (r_pos == PTR_W'(BUF_BYTES - 1)) ? '0 : r_pos + 1'b1;
    assign slot_wr_inc = (r_slot_wr == SLOT_W'(SLOTS - 1)) ? '0 : r_slot_wr + 1'b1;
    assign slot_rd_inc = (r_slot_rd == SLOT_W'(SLOTS - 1)) ? '0 : r_slot_rd + 1'b1;

    // A message longer than the free space restarts the fill level at its own length.
    assign fill_sum  = SUM_W'(r_fill) + SUM_W'(len_sat);
    assign fill_base = (fill_sum > SUM_W'(BUF_BYTES)) ? '0 : r_fill;

    assign head_none = r_empty || !r_desc_rd.valid;
    assign is_pop    = (r_kind == vlmf_pkg::KIND_POP);
    assign too_long  = (r_desc_rd.len > r_limit);

    assign o_sts.clr_done   = (r_clr_idx == SLOT_W'(SLOTS - 1));
    assign o_sts.stream     = !head_none && is_pop && !too_long && (r_desc_rd.len != '0);
    assign o_sts.last_issue = (r_cnt == LEN_W'(1));
    assign q_after          = 3'(q_count) + 3'(r_rd_pend) - 3'(q_deq);
    assign o_sts.q_room     = (q_after < 3'd2);
    assign o_sts.rd_room    = (q_after < 3'd2);

    // Descriptor write port: clearing sweep, push of a last byte, or retiring the head.
    always_comb begin
        desc_we = 1'b0;
        desc_wa = r_slot_rd;
        desc_wd = '0;
        if (i_cmd.clr_step) begin
            desc_we = 1'b1;
            desc_wa = r_clr_idx;
        end else if (i_cmd.push && i_byte_last) begin
            desc_we       = 1'b1;
            desc_wa       = r_slot_wr;
            desc_wd.valid = 1'b1;
            desc_wd.start = start_now;
            desc_wd.len   = len_sat;
        end else if (i_cmd.resolve && !head_none && is_pop) begin
            desc_we = 1'b1;
        end
    end

    // Result source: a landing byte read, or an immediate result of a resolve.
    always_comb begin
        enq      = 1'b0;
        enq_item = '0;
        if (r_rd_pend) begin
            enq                 = 1'b1;
            enq_item.out_byte   = r_rd_data;
            enq_item.out_last   = r_rd_last;
            enq_item.out_length = r_len;
            enq_item.status     = vlmf_pkg::ST_OK;
        end else if (i_cmd.resolve && !o_sts.stream) begin
            enq               = 1'b1;
            enq_item.out_last = 1'b1;
            if (head_none) begin
                enq_item.status = vlmf_pkg::ST_EMPTY;
            end else begin
                enq_item.out_length = r_desc_rd.len;
                enq_item.status     = (is_pop && too_long) ? vlmf_pkg::ST_TOO_LONG
                                                           : vlmf_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_msg_start <= '0;
            r_in_msg    <= 1'b0;
            r_fill      <= '0;
            r_slot_wr   <= '0;
            r_slot_rd   <= '0;
            r_clr_idx   <= '0;
            r_cnt       <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.issue;
            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.push) begin
                r_wr_ptr <= wr_ptr_inc;
                if (!r_in_msg) begin
                    r_msg_start <= r_wr_ptr;
                    r_fill      <= fill_base + FILL_W'(len_sat);
                end
                r_in_msg <= !i_byte_last;
                if (i_byte_last) begin
                    r_slot_wr <= slot_wr_inc;
                end
            end
            if (i_cmd.resolve) begin
                if (is_pop && !(r_empty && head_none)) begin
                    r_slot_rd <= slot_rd_inc;
                end
                if (!head_none && is_pop && !too_long) begin
                    r_fill <= (r_fill > FILL_W'(r_desc_rd.len))
                              ? r_fill - FILL_W'(r_desc_rd.len) : '0;
                end
                if (o_sts.stream) begin
                    r_cnt <= r_desc_rd.len;
                end
            end
            if (i_cmd.issue) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Request latches and streaming payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req) begin
            r_kind  <= i_kind;
            r_limit <= i_read_limit;
            r_empty <= (r_slot_rd == r_slot_wr);
        end
        if (i_cmd.resolve && o_sts.stream) begin
            r_pos <= r_desc_rd.start;
            r_len <= r_desc_rd.len;
        end
        if (i_cmd.issue) begin
            r_pos     <= pos_inc;
            r_rd_last <= (r_cnt == LEN_W'(1));
        end
    end

    // Byte ring.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_byte_mem[r_wr_ptr] <= i_data_byte;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_byte_mem[r_pos];
        end
    end

    // Descriptor ring.
    always_ff @(posedge i_clk) begin
        if (desc_we) begin
            r_desc_mem[desc_wa] <= desc_wd;
        end
        if (i_cmd.req) begin
            r_desc_rd <= r_desc_mem[r_slot_rd];
        end
    end

    vlmf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_item  (enq_item),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (o_item),
        .o_count (q_count),
        .o_deq   (q_deq)
    );

endmodule

// ----- hw/rtl/vlmf_ctrl.sv -----
`timescale 1ns / 1ps

// Controller: sequences the clearing sweep, request decode and byte streaming.
module vlmf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [vlmf_pkg::KIND_W-1:0] i_kind,
    output logic                        o_stall,
    input  vlmf_pkg::t_sts              i_sts,
    output vlmf_pkg::t_cmd              o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DESC,
        S_STREAM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == vlmf_pkg::KIND_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else if (i_kind == vlmf_pkg::KIND_POP
                                 || i_kind == vlmf_pkg::KIND_PEEK) begin
                        o_cmd.req = 1'b1;
                        n_state   = S_DESC;
                    end
                end
            end
            S_DESC: begin
                if (i_sts.q_room) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = i_sts.stream ? S_STREAM : S_IDLE;
                end
            end
            S_STREAM: begin
                if (i_sts.rd_room) begin
                    o_cmd.issue = 1'b1;
                    if (i_sts.last_issue) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
